FILE: rtl/lcw_pkg.sv
// Shared types, constants and command codes of the LCW decompressor.
package lcw_pkg;

  // History holds 2^OUT_ADDR_BITS bytes; the write pointer needs one more bit.
  localparam int unsigned OUT_ADDR_BITS = 16;
  localparam int unsigned HIST_DEPTH    = 1 << OUT_ADDR_BITS;
  localparam int unsigned SRC_W         = (OUT_ADDR_BITS + 1 > 17) ? OUT_ADDR_BITS + 1 : 17;
  localparam int unsigned IN_W          = 8;
  localparam int unsigned OUT_W         = 32;

  typedef logic [OUT_ADDR_BITS-1:0] haddr_t;
  typedef logic [OUT_ADDR_BITS:0]   wptr_t;
  typedef logic [SRC_W-1:0]         src_t;

  localparam logic       OP_PUSH    = 1'b0;
  localparam logic       OP_ADVANCE = 1'b1;

  localparam logic [7:0] CMD_FILL   = 8'hFE;
  localparam logic [7:0] CMD_XCOPY  = 8'hFF;

  typedef enum logic [2:0] {
    ST_CMD,
    ST_REL,
    ST_LIT,
    ST_W1LO,
    ST_W1HI,
    ST_W2LO,
    ST_W2HI,
    ST_COLOR
  } parse_state_e;

  // Result of one request as decided by the parser; the byte of a copy
  // arrives from the history memory in the cycle after the request.
  typedef struct packed {
    logic       emit;
    logic       is_copy;
    logic [7:0] data;
    haddr_t     addr;
    logic       need;
    logic       done;
    logic       err;
  } lcw_res_t;

endpackage

FILE: rtl/lcw_lz_decompressor.sv
// Top level of the LCW decompressor: parser, history memory and result pipeline.
//
//   channel   dir  handshake                  tdata / tuser
//   s_axis    in   s_axis_tvalid/tready       tdata[7:0] data_byte, tuser op
//   m_axis    out  m_axis_tvalid/tready       tdata: out_valid .. error_flag
//
// One request is taken per cycle unless stalled; results pass s1_q and m_data_q.
// The rate is set by the history memory, which is read once (copy source) and
// written once (output byte) per cycle; a read of the byte written in the
// same cycle is forwarded. Reset clears the parser state and valid flags;
// the history needs no clearing. A stalled result stops the pipeline and input.
module lcw_lz_decompressor import lcw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic             s_axis_tuser_i,   // [0] op
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o    // [0] out_valid, [8:1] out_byte,
                                             // [24:9] out_addr, [25] need_byte,
                                             // [26] done_res, [27] error_flag
);

  logic                         s_accept;
  logic                         move;
  lcw_res_t                     res;
  logic                         rd_en;
  haddr_t                       rd_addr;
  logic                         s1_valid_q;
  lcw_res_t                     s1_q;
  logic [7:0]                   rdata;
  logic [7:0]                   byte_fin;
  logic                         wr_en;
  logic                         fwd_q;
  logic [7:0]                   fwd_data_q;
  logic                         m_valid_q;
  logic [OUT_W-1:0]             m_data_q;
  logic [OUT_W-1:0]             m_data_d;
  logic [OUT_ADDR_BITS+15:0]    addr_wide;

  assign move            = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || move;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  lcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (s_accept),
    .op_i      (s_axis_tuser_i),
    .byte_i    (s_axis_tdata_i[7:0]),
    .res_o     (res),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr)
  );

  assign byte_fin = s1_q.is_copy ? (fwd_q ? fwd_data_q : rdata) : s1_q.data;
  assign wr_en    = s1_valid_q && s1_q.emit && move;

  lcw_ram #(
    .WIDTH (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_q.addr),
    .wdata_i (byte_fin),
    .re_i    (s_accept && rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (s_accept) begin
      s1_valid_q <= 1'b1;
      // The memory returns the old byte when it is written in the same cycle.
      fwd_q      <= wr_en && (rd_addr == s1_q.addr);
    end else if (move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_q       <= res;
      fwd_data_q <= byte_fin;
    end
  end

  assign addr_wide = {16'd0, s1_q.addr};

  always_comb begin
    m_data_d        = '0;
    m_data_d[0]     = s1_q.emit;
    m_data_d[8:1]   = s1_q.emit ? byte_fin : 8'h00;
    m_data_d[24:9]  = s1_q.emit ? addr_wide[15:0] : 16'h0000;
    m_data_d[25]    = s1_q.need;
    m_data_d[26]    = s1_q.done;
    m_data_d[27]    = s1_q.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (move) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

FILE: rtl/lcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lcw_ctrl.sv
// Command parser and run sequencer: holds all decoder state except the history.
module lcw_ctrl import lcw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_i,
  input  logic       op_i,
  input  logic [7:0] byte_i,
  output lcw_res_t   res_o,
  output logic       rd_en_o,
  output haddr_t     rd_addr_o
);

  parse_state_e st_q, st_d;
  wptr_t        wp_q, wp_d;
  logic [15:0]  run_q, run_d;
  src_t         src_q, src_d;
  logic [7:0]   cmd_q, cmd_d;
  logic [7:0]   wl_q, wl_d;
  logic [7:0]   fill_q, fill_d;
  logic         done_q, done_d;
  logic         err_q, err_d;

  logic         active;
  logic         pending;
  logic         take;
  logic         emit_req;
  logic         emit_ok;
  logic         copy_rd;
  logic [7:0]   val;
  logic [15:0]  word;
  logic [11:0]  rel_dist;

  assign active   = !done_q && !err_q;
  assign pending  = (st_q == ST_CMD) && (run_q != 16'd0);
  assign take     = req_i && active && (op_i == OP_PUSH) && !pending;
  assign word     = {byte_i, wl_q};
  assign rel_dist = {cmd_q[3:0], byte_i};

  // Next parse state.
  always_comb begin
    st_d = st_q;
    if (take) begin
      case (st_q)
        ST_CMD: begin
          if (!byte_i[7]) begin
            st_d = ST_REL;
          end else if (!byte_i[6]) begin
            // A literal of length zero is the end marker.
            st_d = (byte_i[5:0] == 6'd0) ? ST_CMD : ST_LIT;
          end else begin
            st_d = ST_W1LO;
          end
        end
        ST_REL:  st_d = ST_CMD;
        ST_LIT: begin
          if (!wp_q[OUT_ADDR_BITS] && run_q == 16'd1) begin
            st_d = ST_CMD;
          end
        end
        ST_W1LO: st_d = ST_W1HI;
        ST_W2LO: st_d = ST_W2HI;
        ST_W1HI: begin
          if (cmd_q == CMD_FILL) begin
            st_d = ST_COLOR;
          end else if (cmd_q == CMD_XCOPY) begin
            st_d = ST_W2LO;
          end else begin
            st_d = ST_CMD;
          end
        end
        ST_W2HI:  st_d = ST_CMD;
        ST_COLOR: st_d = ST_CMD;
        default:  st_d = ST_CMD;
      endcase
    end
  end

  // Datapath registers and the byte this request produces.
  always_comb begin
    wp_d     = wp_q;
    run_d    = run_q;
    src_d    = src_q;
    cmd_d    = cmd_q;
    wl_d     = wl_q;
    fill_d   = fill_q;
    done_d   = done_q;
    err_d    = err_q;
    emit_req = 1'b0;
    emit_ok  = 1'b0;
    copy_rd  = 1'b0;
    val      = 8'h00;
    if (req_i && active) begin
      if (op_i == OP_ADVANCE) begin
        if (!pending) begin
          err_d = 1'b1;
        end else if (cmd_q == CMD_FILL) begin
          emit_req = 1'b1;
          val      = fill_q;
        end else if (src_q >= src_t'(wp_q)) begin
          // Copy source not written yet.
          err_d = 1'b1;
        end else begin
          copy_rd  = 1'b1;
          emit_req = 1'b1;
          src_d    = src_q + 1'b1;
        end
      end else if (pending) begin
        err_d = 1'b1;
      end else begin
        case (st_q)
          ST_CMD: begin
            cmd_d = byte_i;
            if (byte_i[7] && !byte_i[6]) begin
              run_d = 16'(byte_i[5:0]);
              if (byte_i[5:0] == 6'd0) begin
                done_d = 1'b1;
              end
            end
          end
          ST_REL: begin
            if (src_t'(rel_dist) > src_t'(wp_q)) begin
              err_d = 1'b1;
            end else begin
              src_d = src_t'(wp_q) - src_t'(rel_dist);
              run_d = 16'(cmd_q[6:4]) + 16'd3;
            end
          end
          ST_LIT: begin
            emit_req = 1'b1;
            val      = byte_i;
          end
          ST_W1LO, ST_W2LO: wl_d = byte_i;
          ST_W1HI: begin
            if (cmd_q == CMD_FILL || cmd_q == CMD_XCOPY) begin
              run_d = word;
            end else begin
              src_d = src_t'(word);
              run_d = 16'(cmd_q[5:0]) + 16'd3;
            end
          end
          ST_W2HI:  src_d  = src_t'(word);
          ST_COLOR: fill_d = byte_i;
          default: ;
        endcase
      end
    end
    if (emit_req) begin
      if (wp_q[OUT_ADDR_BITS]) begin
        err_d = 1'b1;
      end else begin
        emit_ok = 1'b1;
        wp_d    = wp_q + 1'b1;
        if (run_q != 16'd0) begin
          run_d = run_q - 1'b1;
        end
      end
    end
  end

  // Result fields, seen after this request has taken effect.
  always_comb begin
    res_o.emit    = emit_ok;
    res_o.is_copy = copy_rd;
    res_o.data    = val;
    res_o.addr    = wp_q[OUT_ADDR_BITS-1:0];
    res_o.done    = done_d;
    res_o.err     = err_d;
    res_o.need    = !done_d && !err_d && !((st_d == ST_CMD) && (run_d != 16'd0));
  end

  assign rd_en_o   = copy_rd;
  assign rd_addr_o = src_q[OUT_ADDR_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_CMD;
      wp_q   <= '0;
      run_q  <= '0;
      src_q  <= '0;
      cmd_q  <= '0;
      wl_q   <= '0;
      fill_q <= '0;
      done_q <= 1'b0;
      err_q  <= 1'b0;
    end else if (req_i) begin
      st_q   <= st_d;
      wp_q   <= wp_d;
      run_q  <= run_d;
      src_q  <= src_d;
      cmd_q  <= cmd_d;
      wl_q   <= wl_d;
      fill_q <= fill_d;
      done_q <= done_d;
      err_q  <= err_d;
    end
  end

endmodule
